FILE: rtl/core/nds_pkg.sv
`timescale 1ns / 1ps
package nds_pkg;

  // fixed widths of the datapath
  localparam int SPACING_W = 32;
  localparam int COEF_W    = 64;
  localparam int DEN_W     = 65;             // l*(l+u) fits in 65 bits
  localparam int Q_W       = 65;             // quotient bits kept before rounding
  localparam int NUM_SHIFT = 49;             // first order: mag * 2^48, one extra bit for rounding
  localparam int NUM_W     = SPACING_W + NUM_SHIFT;
  localparam int HEAD_W    = NUM_W - Q_W;
  localparam int LATENCY   = Q_W + 5;        // accepting edge to result edge

  localparam logic [NUM_W-1:0] NUM_SECOND = NUM_W'(1) << 66;

  // configuration
  localparam int              CFG_ADDR_W   = 3;
  localparam logic            REG_ORDER    = 1'b0;   // word index of derivative_order
  localparam logic [1:0]      ORDER_SECOND = 2'd2;
  localparam logic [1:0]      ORDER_RESET  = 2'd1;

  typedef struct packed {
    logic [SPACING_W-1:0] spacing_left;
    logic [SPACING_W-1:0] spacing_right;
    logic                 boundary_node;
  } in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_lower;
    logic signed [COEF_W-1:0] coef_diag;
    logic signed [COEF_W-1:0] coef_upper;
    logic                     zero_spacing_error;
  } out_t;

endpackage

FILE: rtl/core/nonuniform_difference_stencil.sv
`timescale 1ns / 1ps
// path: a beat accepted with start passes the capture, sum and denominator stages, the
// dividers and the final rounding stage before out_valid rises with its result
// throughput: one node per cycle, busy is never raised; the depth is set by the
// 65-stage restoring dividers, one quotient bit per stage
// the receiver cannot stall, so every beat flows through without backpressure
// reset: rst_n synchronous active low clears valid bits and sets derivative_order to 1
module nonuniform_difference_stencil (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  nds_pkg::in_t                   in_data,
  output logic                           out_valid,
  output nds_pkg::out_t                  out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [nds_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int SW = nds_pkg::SPACING_W;
  localparam int DW = nds_pkg::DEN_W;
  localparam int QW = nds_pkg::Q_W;
  localparam int NW = nds_pkg::NUM_W;
  localparam int CW = nds_pkg::COEF_W;

  // sideband that rides alongside the divider stages
  typedef struct packed {
    logic valid;
    logic zero;     // boundary or zero spacing: row forced to zero
    logic err;
    logic neg_l;
    logic neg_d;
    logic neg_u;
  } side_t;

  // ---------------- configuration register ----------------
  logic [1:0] order_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= nds_pkg::ORDER_RESET;
    end else if (cfg_wr && cfg_paddr[2] == nds_pkg::REG_ORDER) begin
      order_r <= cfg_pwdata[1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == nds_pkg::REG_ORDER) ? {30'd0, order_r} : 32'd0;

  // never stalls: a new beat may enter every cycle
  assign busy = 1'b0;

  // ---------------- stage 1: capture the beat ----------------
  logic            v1_r;
  nds_pkg::in_t    in1_r;
  logic            sec1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    in1_r  <= in_data;
    sec1_r <= (order_r == nds_pkg::ORDER_SECOND);
  end

  // ---------------- stage 2: sum, difference, special cases ----------------
  logic [SW-1:0] l2_r, u2_r, dif2_r;
  logic [SW:0]   s2_r;
  logic          uge2_r, sec2_r;
  side_t         side2_r;
  logic          err1;

  assign err1 = !in1_r.boundary_node &&
                (in1_r.spacing_left == '0 || in1_r.spacing_right == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side2_r.valid <= 1'b0;
    end else begin
      side2_r.valid <= v1_r;
    end
    side2_r.zero  <= in1_r.boundary_node || err1;
    side2_r.err   <= err1;
    side2_r.neg_l <= 1'b0;
    side2_r.neg_d <= 1'b0;
    side2_r.neg_u <= 1'b0;
    l2_r   <= in1_r.spacing_left;
    u2_r   <= in1_r.spacing_right;
    s2_r   <= {1'b0, in1_r.spacing_left} + {1'b0, in1_r.spacing_right};
    uge2_r <= in1_r.spacing_right >= in1_r.spacing_left;
    dif2_r <= (in1_r.spacing_right >= in1_r.spacing_left) ?
              in1_r.spacing_right - in1_r.spacing_left :
              in1_r.spacing_left - in1_r.spacing_right;
    sec2_r <= sec1_r;
  end

  // ---------------- stage 3: denominators and numerators ----------------
  logic [DW-1:0] den_l3_r, den_d3_r, den_u3_r;
  logic [NW-1:0] num_l3_r, num_d3_r, num_u3_r;
  side_t         side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side3_r.valid <= 1'b0;
    end else begin
      side3_r.valid <= side2_r.valid;
    end
    side3_r.zero  <= side2_r.zero;
    side3_r.err   <= side2_r.err;
    // second order: lower and upper positive, diagonal negative
    // first order: lower negative, diagonal takes the sign of u-l
    side3_r.neg_l <= !sec2_r;
    side3_r.neg_d <= sec2_r || !uge2_r;
    side3_r.neg_u <= 1'b0;
    den_l3_r <= {{(DW-SW){1'b0}}, l2_r} * {{(DW-SW-1){1'b0}}, s2_r};
    den_u3_r <= {{(DW-SW){1'b0}}, u2_r} * {{(DW-SW-1){1'b0}}, s2_r};
    den_d3_r <= {{(DW-SW){1'b0}}, l2_r} * {{(DW-SW){1'b0}}, u2_r};
    num_l3_r <= sec2_r ? nds_pkg::NUM_SECOND : {u2_r, {nds_pkg::NUM_SHIFT{1'b0}}};
    num_d3_r <= sec2_r ? nds_pkg::NUM_SECOND : {dif2_r, {nds_pkg::NUM_SHIFT{1'b0}}};
    num_u3_r <= sec2_r ? nds_pkg::NUM_SECOND : {l2_r, {nds_pkg::NUM_SHIFT{1'b0}}};
  end

  // ---------------- divider pipelines, one per coefficient ----------------
  logic [QW-1:0] quo_l, quo_d, quo_u;
  logic          ovf_l, ovf_d, ovf_u;

  nds_div u_div_l (.clk(clk), .num(num_l3_r), .den(den_l3_r), .quo(quo_l), .ovf(ovf_l));
  nds_div u_div_d (.clk(clk), .num(num_d3_r), .den(den_d3_r), .quo(quo_d), .ovf(ovf_d));
  nds_div u_div_u (.clk(clk), .num(num_u3_r), .den(den_u3_r), .quo(quo_u), .ovf(ovf_u));

  // sideband delay line matching the divider's stages
  side_t side_r   [0:QW];
  side_t side_nxt [0:QW];

  // valid bits drop out while reset is held
  always_comb begin
    side_nxt[0]       = side3_r;
    side_nxt[0].valid = rst_n && side3_r.valid;
    for (int k = 1; k <= QW; k++) begin
      side_nxt[k]       = side_r[k-1];
      side_nxt[k].valid = rst_n && side_r[k-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= QW; k++) begin
      side_r[k] <= side_nxt[k];
    end
  end

  // ---------------- final stage: round half away, saturate, sign ----------------
  // quotient carries one extra fraction bit; (q+1)>>1 rounds the magnitude
  function automatic logic [CW-1:0] finish(input logic [QW-1:0] q, input logic ovf,
                                           input logic neg);
    logic [QW:0]   qp;
    logic [QW-1:0] m;
    logic [QW-1:0] limit;
    logic [CW-1:0] mag;
    qp    = {1'b0, q} + {{QW{1'b0}}, 1'b1};
    m     = qp[QW:1];
    limit = neg ? {2'b01, {(QW-2){1'b0}}} : {2'b00, {(QW-2){1'b1}}};
    mag   = (ovf || m > limit) ? limit[CW-1:0] : m[CW-1:0];
    return neg ? (CW'(0) - mag) : mag;
  endfunction

  side_t         side_f;
  logic          out_valid_r;
  nds_pkg::out_t out_data_r;

  assign side_f = side_r[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_f.valid;
    end
    out_data_r.coef_lower <= side_f.zero ? '0 : finish(quo_l, ovf_l, side_f.neg_l);
    out_data_r.coef_diag  <= side_f.zero ? '0 : finish(quo_d, ovf_d, side_f.neg_d);
    out_data_r.coef_upper <= side_f.zero ? '0 : finish(quo_u, ovf_u, side_f.neg_u);
    out_data_r.zero_spacing_error <= side_f.err;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/nds_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
module nds_div (
  input  logic                      clk,
  input  logic [nds_pkg::NUM_W-1:0] num,
  input  logic [nds_pkg::DEN_W-1:0] den,
  output logic [nds_pkg::Q_W-1:0]   quo,
  output logic                      ovf
);

  localparam int DW = nds_pkg::DEN_W;
  localparam int QW = nds_pkg::Q_W;
  localparam int HW = nds_pkg::HEAD_W;

  logic [DW-1:0] rem_r   [0:QW];
  logic [DW-1:0] den_r   [0:QW];
  logic [QW-1:0] quo_r   [0:QW];
  logic [QW-1:0] low_r   [0:QW];
  logic          ovf_r   [0:QW];

  logic [DW-1:0] rem_nxt [1:QW];
  logic [QW-1:0] quo_nxt [1:QW];
  logic [DW:0]   trial   [1:QW];
  logic [DW:0]   diff    [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      trial[k]   = {rem_r[k-1], low_r[k-1][QW-1]};
      diff[k]    = trial[k] - {1'b0, den_r[k-1]};
      rem_nxt[k] = diff[k][DW] ? trial[k][DW-1:0] : diff[k][DW-1:0];
      quo_nxt[k] = {quo_r[k-1][QW-2:0], ~diff[k][DW]};
    end
  end

  always_ff @(posedge clk) begin
    // head of the numerator already at or above den means quotient overflow
    ovf_r[0] <= {{(DW-HW){1'b0}}, num[nds_pkg::NUM_W-1:QW]} >= den;
    rem_r[0] <= {{(DW-HW){1'b0}}, num[nds_pkg::NUM_W-1:QW]};
    low_r[0] <= num[QW-1:0];
    den_r[0] <= den;
    quo_r[0] <= '0;
    for (int k = 1; k <= QW; k++) begin
      ovf_r[k] <= ovf_r[k-1];
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
      den_r[k] <= den_r[k-1];
      quo_r[k] <= quo_nxt[k];
    end
  end

  assign quo = quo_r[QW];
  assign ovf = ovf_r[QW];

endmodule

FILE: rtl/core/nds_checker.sv
`timescale 1ns / 1ps
module nds_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input nds_pkg::in_t                   in_data,
  input logic                           out_valid,
  input nds_pkg::out_t                  out_data
);

  // the block never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted beat yields exactly one strobe at fixed latency
  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(nds_pkg::LATENCY) out_valid)
    else $error("result strobe missing");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(nds_pkg::LATENCY) !out_valid)
    else $error("result strobe without a beat");

  // a boundary node gives an all zero row
  a_boundary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.boundary_node) |-> ##(nds_pkg::LATENCY)
    (out_data.coef_lower == '0 && out_data.coef_diag == '0 &&
     out_data.coef_upper == '0 && !out_data.zero_spacing_error))
    else $error("boundary row not zero");

  // an error row carries no coefficients
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_spacing_error) |->
    (out_data.coef_lower == '0 && out_data.coef_diag == '0 && out_data.coef_upper == '0))
    else $error("error row not zero");

endmodule

bind nonuniform_difference_stencil nds_checker u_nds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
